>>> src/gms_pkg.sv
// Shared types, constants and helpers for the grid maze shortest path block.
// No dependencies; every other file of the block but gms_ram refers to this package.
package gms_pkg;

   localparam int MAX_ROWS  = 32;
   localparam int MAX_COLS  = 32;
   localparam int NCELLS    = MAX_ROWS * MAX_COLS;
   localparam int CELL_W    = $clog2(NCELLS);
   localparam int POS_W     = $clog2(NCELLS + 1);
   localparam int LEN_W     = POS_W;
   localparam int ROW_W     = $clog2(MAX_ROWS + 1);
   localparam int COL_W     = $clog2(MAX_COLS + 1);
   localparam int CFG_W     = 6;
   localparam int IDX_W     = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [IDX_W-1:0] SHOW_MAX = {IDX_W{1'b1}};

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [1:0] KIND_OPEN  = 2'd0;
   localparam logic [1:0] KIND_WALL  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam logic RES_SUMMARY = 1'b0;
   localparam logic RES_STEP    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_CLEAR, ST_DIV, ST_SEED, ST_POP, ST_POP_WAIT,
      ST_NB, ST_NB_EVAL, ST_CHK, ST_CHK_WAIT, ST_TRACE, ST_TRACE_EVAL, ST_RD_WAIT
   } state_type;

   typedef struct packed {
      logic [CELL_W-1:0] pos;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } cell_type;

   typedef struct packed {
      logic             action;
      logic [1:0]       cell_kind;
      logic             last_cell;
      logic [IDX_W-1:0] step_index;
   } req_type;

   typedef struct packed {
      logic             result_kind;
      logic             reachable;
      logic [IDX_W-1:0] path_length;
      logic [1:0]       direction;
      logic             index_out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CFG_W-1:0]     wr_data;
   } csr_type;

   function automatic logic [ROW_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
      logic [ROW_W-1:0] r;
      if (v == '0) r = ROW_W'(1);
      else if (32'(v) > MAX_ROWS) r = ROW_W'(MAX_ROWS);
      else r = ROW_W'(v);
      return r;
   endfunction

   function automatic logic [COL_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) r = COL_W'(1);
      else if (32'(v) > MAX_COLS) r = COL_W'(MAX_COLS);
      else r = COL_W'(v);
      return r;
   endfunction

endpackage

>>> src/gms_req_if.sv
// Request channel of the grid maze shortest path block.
// Depends on gms_pkg for the payload type.
interface gms_req_if;
   logic             valid;
   logic             ready;
   gms_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/gms_rsp_if.sv
// Response channel of the grid maze shortest path block.
// Depends on gms_pkg for the payload type.
interface gms_rsp_if;
   logic             valid;
   logic             ready;
   gms_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/gms_csr_if.sv
// Register write channel of the grid maze shortest path block.
// Depends on gms_pkg for the payload type.
interface gms_csr_if;
   logic             valid;
   logic             ready;
   gms_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/gms_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gms_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> src/grid_maze_shortest_path.sv
// Lee maze router: loads a grid cell by cell, runs a breadth-first search and
// serves the shortest path one step per request. The load request that
// carries last_cell starts a search: a visited-map clearing pass over all
// NCELLS (1024) cells, start row derivation by repeated subtraction, a queue
// read per dequeued cell, a wall and visited check per neighbour, and a path
// RAM write per backtrace step; each map has a single read port. A step read
// in range waits for the path RAM; one out of range does not.
// Depends on gms_pkg, the gms_*_if interfaces and gms_ram.
module grid_maze_shortest_path (
   input logic       clock,
   input logic       reset,
   gms_req_if.sink   req_ch,
   gms_rsp_if.source rsp_ch,
   gms_csr_if.sink   csr_ch
);
   gms_pkg::state_type state_ff, state_in;
   logic [gms_pkg::CFG_W-1:0]  rows_ff, cols_ff;
   logic [gms_pkg::POS_W-1:0]  load_pos_ff, load_pos_in;
   logic [gms_pkg::CELL_W-1:0] start_pos_ff, start_pos_in, end_pos_ff, end_pos_in;
   logic [1:0]                 seen_ff, seen_in;
   logic [gms_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       found_ff, found_in;
   logic [gms_pkg::POS_W-1:0]  used_ff, used_in, clr_ff, clr_in;
   logic [gms_pkg::POS_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [gms_pkg::POS_W-1:0]  rem_ff, rem_in;
   logic [gms_pkg::ROW_W-1:0]  row_ff, row_in;
   gms_pkg::cell_type          cur_ff, cur_in, nb_ff, nb_in, nb_c;
   logic [1:0]                 dir_ff, dir_in;
   logic [gms_pkg::CELL_W-1:0] trace_ff, trace_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   gms_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic [gms_pkg::ROW_W-1:0]  rows_eff;
   logic [gms_pkg::COL_W-1:0]  cols_eff;
   logic [gms_pkg::POS_W-1:0]  total, cols_e, nb_pos, trace_e, trace_prev;
   logic                       nb_ok, nb_go, req_fire, step_oor;
   logic [gms_pkg::IDX_W-1:0]  shown;

   logic                       wall_we, wall_wd, wall_rd;
   logic                       vis_we, vis_wd, vis_rd;
   logic [gms_pkg::CELL_W-1:0] wall_wa, vis_wa, vis_ra;
   logic                       arr_we;
   logic [1:0]                 arr_rd;
   logic                       q_we;
   logic [gms_pkg::CELL_W-1:0] q_wa;
   gms_pkg::cell_type          q_wd;
   logic [$bits(gms_pkg::cell_type)-1:0] q_rd;
   logic                       path_we;
   logic [1:0]                 path_rd;
   logic [gms_pkg::CELL_W-1:0] path_ra;

   assign rows_eff = gms_pkg::clamp_rows(rows_ff);
   assign cols_eff = gms_pkg::clamp_cols(cols_ff);
   assign total    = gms_pkg::POS_W'(32'(rows_eff) * 32'(cols_eff));
   assign cols_e   = gms_pkg::POS_W'(cols_eff);
   assign shown    = (32'(len_ff) > 32'(gms_pkg::SHOW_MAX)) ? gms_pkg::SHOW_MAX
                                                            : gms_pkg::IDX_W'(len_ff);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign step_oor = 32'(req_ch.data.step_index) >= 32'(len_ff);
   assign path_ra  = gms_pkg::CELL_W'(len_ff - gms_pkg::LEN_W'(1)
                                      - gms_pkg::LEN_W'(req_ch.data.step_index));
   assign vis_ra   = (state_ff == gms_pkg::ST_CHK) ? end_pos_ff : nb_c.pos;

   assign req_ch.ready = (state_ff == gms_pkg::ST_IDLE) && !rsp_valid_ff;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // neighbour candidate of the current cell in direction dir_ff
   always_comb begin
      nb_c   = cur_ff;
      nb_pos = gms_pkg::POS_W'(cur_ff.pos);
      nb_ok  = 1'b0;
      unique case (dir_ff)
         gms_pkg::DIR_UP: begin
            nb_ok    = cur_ff.row != '0;
            nb_pos   = gms_pkg::POS_W'(cur_ff.pos) - cols_e;
            nb_c.row = cur_ff.row - gms_pkg::ROW_W'(1);
         end
         gms_pkg::DIR_RIGHT: begin
            nb_ok    = (32'(cur_ff.col) + 1) < 32'(cols_eff);
            nb_pos   = gms_pkg::POS_W'(cur_ff.pos) + gms_pkg::POS_W'(1);
            nb_c.col = cur_ff.col + gms_pkg::COL_W'(1);
         end
         gms_pkg::DIR_DOWN: begin
            nb_ok    = (32'(cur_ff.row) + 1) < 32'(rows_eff);
            nb_pos   = gms_pkg::POS_W'(cur_ff.pos) + cols_e;
            nb_c.row = cur_ff.row + gms_pkg::ROW_W'(1);
         end
         gms_pkg::DIR_LEFT: begin
            nb_ok    = cur_ff.col != '0;
            nb_pos   = gms_pkg::POS_W'(cur_ff.pos) - gms_pkg::POS_W'(1);
            nb_c.col = cur_ff.col - gms_pkg::COL_W'(1);
         end
      endcase
      nb_c.pos = nb_pos[gms_pkg::CELL_W-1:0];
      nb_go    = nb_ok && (nb_pos < used_ff);
   end

   // one step back along the arrival direction
   always_comb begin
      trace_e = gms_pkg::POS_W'(trace_ff);
      unique case (arr_rd)
         gms_pkg::DIR_UP:    trace_prev = trace_e + cols_e;
         gms_pkg::DIR_RIGHT: trace_prev = trace_e - gms_pkg::POS_W'(1);
         gms_pkg::DIR_DOWN:  trace_prev = trace_e - cols_e;
         gms_pkg::DIR_LEFT:  trace_prev = trace_e + gms_pkg::POS_W'(1);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      start_pos_in = start_pos_ff;
      end_pos_in   = end_pos_ff;
      seen_in      = seen_ff;
      len_in       = len_ff;
      found_in     = found_ff;
      used_in      = used_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rem_in       = rem_ff;
      row_in       = row_ff;
      cur_in       = cur_ff;
      nb_in        = nb_ff;
      dir_in       = dir_ff;
      trace_in     = trace_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      wall_we = 1'b0;
      wall_wa = load_pos_ff[gms_pkg::CELL_W-1:0];
      wall_wd = req_ch.data.cell_kind == gms_pkg::KIND_WALL;
      vis_we  = 1'b0;
      vis_wa  = nb_ff.pos;
      vis_wd  = 1'b1;
      arr_we  = 1'b0;
      q_we    = 1'b0;
      q_wa    = tail_ff[gms_pkg::CELL_W-1:0];
      q_wd    = nb_ff;
      path_we = 1'b0;

      unique case (state_ff)
         gms_pkg::ST_IDLE: begin
            if (req_fire && req_ch.data.action == gms_pkg::ACT_READ) begin
               if (step_oor) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{gms_pkg::RES_STEP, found_ff, shown, gms_pkg::DIR_UP,
                                   1'b1};
               end else begin
                  state_in = gms_pkg::ST_RD_WAIT;
               end
            end else if (req_fire) begin
               if (load_pos_ff < total) begin
                  wall_we     = 1'b1;
                  load_pos_in = load_pos_ff + gms_pkg::POS_W'(1);
                  if (req_ch.data.cell_kind == gms_pkg::KIND_START) begin
                     start_pos_in = load_pos_ff[gms_pkg::CELL_W-1:0];
                     seen_in[0]   = 1'b1;
                  end
                  if (req_ch.data.cell_kind == gms_pkg::KIND_END) begin
                     end_pos_in = load_pos_ff[gms_pkg::CELL_W-1:0];
                     seen_in[1] = 1'b1;
                  end
               end
               if (req_ch.data.last_cell) begin
                  state_in = gms_pkg::ST_START;
               end
            end
         end
         gms_pkg::ST_START: begin
            used_in     = (load_pos_ff < total) ? load_pos_ff : total;
            load_pos_in = '0;
            seen_in     = '0;
            found_in    = 1'b0;
            len_in      = '0;
            clr_in      = '0;
            if (seen_ff == 2'b11 && gms_pkg::POS_W'(start_pos_ff) < used_in
                && gms_pkg::POS_W'(end_pos_ff) < used_in) begin
               state_in = gms_pkg::ST_CLEAR;
            end else begin
               state_in     = gms_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{gms_pkg::RES_SUMMARY, 1'b0, '0, gms_pkg::DIR_UP, 1'b0};
            end
         end
         gms_pkg::ST_CLEAR: begin
            vis_we = 1'b1;
            vis_wa = clr_ff[gms_pkg::CELL_W-1:0];
            vis_wd = 1'b0;
            clr_in = clr_ff + gms_pkg::POS_W'(1);
            if (32'(clr_ff) == gms_pkg::NCELLS - 1) begin
               state_in = gms_pkg::ST_DIV;
               rem_in   = gms_pkg::POS_W'(start_pos_ff);
               row_in   = '0;
            end
         end
         gms_pkg::ST_DIV: begin
            if (rem_ff >= cols_e) begin
               rem_in = rem_ff - cols_e;
               row_in = row_ff + gms_pkg::ROW_W'(1);
            end else begin
               state_in = gms_pkg::ST_SEED;
            end
         end
         gms_pkg::ST_SEED: begin
            vis_we   = 1'b1;
            vis_wa   = start_pos_ff;
            q_we     = 1'b1;
            q_wa     = '0;
            q_wd     = '{start_pos_ff, row_ff, gms_pkg::COL_W'(rem_ff)};
            head_in  = '0;
            tail_in  = gms_pkg::POS_W'(1);
            state_in = gms_pkg::ST_POP;
         end
         gms_pkg::ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = gms_pkg::ST_CHK;
            end else begin
               head_in  = head_ff + gms_pkg::POS_W'(1);
               state_in = gms_pkg::ST_POP_WAIT;
            end
         end
         gms_pkg::ST_POP_WAIT: begin
            cur_in   = gms_pkg::cell_type'(q_rd);
            dir_in   = gms_pkg::DIR_UP;
            state_in = gms_pkg::ST_NB;
         end
         gms_pkg::ST_NB: begin
            if (nb_go) begin
               nb_in    = nb_c;
               state_in = gms_pkg::ST_NB_EVAL;
            end else if (dir_ff == gms_pkg::DIR_LEFT) begin
               state_in = gms_pkg::ST_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         gms_pkg::ST_NB_EVAL: begin
            if (!wall_rd && !vis_rd) begin
               vis_we = 1'b1;
               arr_we = 1'b1;
               if (32'(tail_ff) < gms_pkg::NCELLS) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + gms_pkg::POS_W'(1);
               end
            end
            if (dir_ff == gms_pkg::DIR_LEFT) begin
               state_in = gms_pkg::ST_POP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = gms_pkg::ST_NB;
            end
         end
         gms_pkg::ST_CHK: begin
            state_in = gms_pkg::ST_CHK_WAIT;
         end
         gms_pkg::ST_CHK_WAIT: begin
            if (vis_rd) begin
               found_in = 1'b1;
               trace_in = end_pos_ff;
               len_in   = '0;
               state_in = gms_pkg::ST_TRACE;
            end else begin
               state_in     = gms_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{gms_pkg::RES_SUMMARY, 1'b0, '0, gms_pkg::DIR_UP, 1'b0};
            end
         end
         gms_pkg::ST_TRACE: begin
            if (trace_ff == start_pos_ff || 32'(len_ff) >= gms_pkg::NCELLS) begin
               state_in     = gms_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{gms_pkg::RES_SUMMARY, found_ff, shown, gms_pkg::DIR_UP,
                                1'b0};
            end else begin
               state_in = gms_pkg::ST_TRACE_EVAL;
            end
         end
         gms_pkg::ST_TRACE_EVAL: begin
            path_we  = 1'b1;
            len_in   = len_ff + gms_pkg::LEN_W'(1);
            trace_in = trace_prev[gms_pkg::CELL_W-1:0];
            state_in = gms_pkg::ST_TRACE;
         end
         gms_pkg::ST_RD_WAIT: begin
            state_in     = gms_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{gms_pkg::RES_STEP, found_ff, shown, path_rd, 1'b0};
         end
         default: begin
            state_in = gms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gms_pkg::ST_IDLE;
         rows_ff      <= gms_pkg::CFG_W'(32);
         cols_ff      <= gms_pkg::CFG_W'(32);
         load_pos_ff  <= '0;
         start_pos_ff <= '0;
         end_pos_ff   <= '0;
         seen_ff      <= '0;
         len_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         start_pos_ff <= start_pos_in;
         end_pos_ff   <= end_pos_in;
         seen_ff      <= seen_in;
         len_ff       <= len_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.data.reg_index == gms_pkg::CSR_GRID_ROWS) begin
               rows_ff <= csr_ch.data.wr_data;
            end else if (csr_ch.data.reg_index == gms_pkg::CSR_GRID_COLS) begin
               cols_ff <= csr_ch.data.wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      used_ff     <= used_in;
      clr_ff      <= clr_in;
      rem_ff      <= rem_in;
      row_ff      <= row_in;
      cur_ff      <= cur_in;
      nb_ff       <= nb_in;
      dir_ff      <= dir_in;
      trace_ff    <= trace_in;
      rsp_data_ff <= rsp_data_in;
   end

   gms_ram #(.WIDTH(1), .DEPTH(gms_pkg::NCELLS)) u_wall (
      .clock(clock), .wr_en(wall_we), .wr_addr(wall_wa), .wr_data(wall_wd),
      .rd_addr(nb_c.pos), .rd_data(wall_rd)
   );

   gms_ram #(.WIDTH(1), .DEPTH(gms_pkg::NCELLS)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
      .rd_addr(vis_ra), .rd_data(vis_rd)
   );

   gms_ram #(.WIDTH(2), .DEPTH(gms_pkg::NCELLS)) u_arrival (
      .clock(clock), .wr_en(arr_we), .wr_addr(nb_ff.pos), .wr_data(dir_ff),
      .rd_addr(trace_ff), .rd_data(arr_rd)
   );

   gms_ram #(.WIDTH($bits(gms_pkg::cell_type)), .DEPTH(gms_pkg::NCELLS)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(head_ff[gms_pkg::CELL_W-1:0]), .rd_data(q_rd)
   );

   gms_ram #(.WIDTH(2), .DEPTH(gms_pkg::NCELLS)) u_path (
      .clock(clock), .wr_en(path_we), .wr_addr(len_ff[gms_pkg::CELL_W-1:0]),
      .wr_data(arr_rd), .rd_addr(path_ra), .rd_data(path_rd)
   );

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ch.ready)
      else $error("request taken while a response is pending");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("frontier queue head passed tail");

   a_last_starts_search: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.data.action == gms_pkg::ACT_LOAD && req_ch.data.last_cell
      |=> state_ff == gms_pkg::ST_START)
      else $error("last cell did not start a search");

   a_trace_only_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == gms_pkg::ST_TRACE_EVAL |-> found_ff)
      else $error("backtrace without a reached end");

endmodule
